FILE: rtl/psa_pkg.sv
// Shared types and codes for the pattern-only sparse matrix-vector accumulator.
// No dependencies; imported by psa_accum, psa_scale and pattern_spmv_accumulate.
package psa_pkg;

    // input item kinds, carried on s_tuser
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_ENTRY = 2'd1;
    localparam logic [1:0] MODE_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SCALED_MODE = 2'd0;
    localparam logic [1:0] CFG_ALPHA_GAIN  = 2'd1;
    localparam logic [1:0] CFG_BETA_GAIN   = 2'd2;

    localparam int INDEX_W = 12;
    localparam int VALUE_W = 32;
    localparam int ACC_W   = 48;
    localparam int ROW_W   = 16;

    // finished row handed from the accumulator to the scaler
    typedef struct packed {
        logic                      valid;
        logic signed [ACC_W-1:0]   sum;
        logic signed [VALUE_W-1:0] old;
        logic                      clip;
        logic [ROW_W-1:0]          row;
    } fin_t;

endpackage

FILE: rtl/psa_vec_mem.sv
// Dense vector store: one write port, one read port, registered read data.
// Depends on nothing beyond its parameter.
module psa_vec_mem #(
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
)(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/psa_accum.sv
// Row accumulator: adds the store read data to the row sum, saturates at 48 bits,
// closes rows and counts them. Uses psa_pkg.
module psa_accum
    import psa_pkg::*;
#(
    parameter int MAX_ROWS = 65536
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  logic [1:0]                mode,
    input  logic                      idx_ok,
    input  logic                      last,
    input  logic signed [VALUE_W-1:0] old,
    input  logic [VALUE_W-1:0]        rd_data,
    output fin_t                      fin,
    output logic                      pend
);

    localparam int CW = $clog2(MAX_ROWS);
    localparam logic [CW-1:0] ROW_LAST = CW'(MAX_ROWS - 1);
    localparam logic signed [ACC_W:0] ACC_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W:0] ACC_MIN = 49'sh1_8000_0000_0000;

    logic                      p1_add_reg;
    logic                      p1_fin_reg;
    logic                      p1_ok_reg;
    logic signed [VALUE_W-1:0] p1_old_reg;
    logic signed [ACC_W-1:0]   row_sum_reg;
    logic                      row_clip_reg;
    logic [CW-1:0]             row_cnt_reg;

    logic signed [VALUE_W-1:0] elem;
    logic signed [ACC_W:0]     sum_wide;
    logic signed [ACC_W-1:0]   sum_sat;
    logic                      clip_now;
    logic [CW+ROW_W-1:0]       row_wide;

    always_comb
    begin
        elem = (p1_add_reg && p1_ok_reg) ? $signed(rd_data) : '0;
        sum_wide = row_sum_reg + elem;
        sum_sat  = sum_wide[ACC_W-1:0];
        clip_now = row_clip_reg;
        if (sum_wide > ACC_MAX)
        begin
            sum_sat  = ACC_MAX[ACC_W-1:0];
            clip_now = 1'b1;
        end
        else if (sum_wide < ACC_MIN)
        begin
            sum_sat  = ACC_MIN[ACC_W-1:0];
            clip_now = 1'b1;
        end
        row_wide = {{ROW_W{1'b0}}, row_cnt_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_add_reg   <= 1'b0;
            p1_fin_reg   <= 1'b0;
            p1_ok_reg    <= 1'b0;
            p1_old_reg   <= '0;
            row_sum_reg  <= '0;
            row_clip_reg <= 1'b0;
            row_cnt_reg  <= '0;
        end
        else
        begin
            p1_add_reg <= take && (mode == MODE_ENTRY);
            p1_fin_reg <= take && (((mode == MODE_ENTRY) && last) || (mode == MODE_EMPTY));
            p1_ok_reg  <= idx_ok;
            p1_old_reg <= old;
            if (p1_fin_reg)
            begin
                row_sum_reg  <= '0;
                row_clip_reg <= 1'b0;
                row_cnt_reg  <= (row_cnt_reg == ROW_LAST) ? '0 : row_cnt_reg + 1'b1;
            end
            else if (p1_add_reg)
            begin
                row_sum_reg  <= sum_sat;
                row_clip_reg <= clip_now;
            end
        end
    end

    assign fin.valid = p1_fin_reg;
    assign fin.sum   = sum_sat;
    assign fin.old   = p1_old_reg;
    assign fin.clip  = clip_now;
    assign fin.row   = row_wide[ROW_W-1:0];
    assign pend      = p1_fin_reg;

endmodule

FILE: rtl/psa_scale.sv
// Row result unit: optional alpha*sum + beta*old in Q16.16 with round-half-up,
// 32-bit saturation, and the output register. Uses psa_pkg.
module psa_scale
    import psa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      scaled_mode,
    input  logic signed [VALUE_W-1:0] alpha_gain,
    input  logic signed [VALUE_W-1:0] beta_gain,
    input  fin_t                      fin,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [VALUE_W-1:0]        out_result,
    output logic [ROW_W-1:0]          out_row,
    output logic                      out_sat,
    output logic                      idle
);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SUM, ST_FIN} state_t;

    localparam logic signed [65:0] RES_MAX = 66'sh0_0000_0000_7FFF_FFFF;
    localparam logic signed [65:0] RES_MIN = -66'sh0_0000_0000_8000_0000;

    state_t                    state_reg, state_next;
    logic signed [ACC_W-1:0]   sum_reg, sum_next;
    logic signed [VALUE_W-1:0] old_reg, old_next;
    logic                      clip_reg, clip_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic signed [63:0]        prod_hi_reg, prod_hi_next;
    logic signed [48:0]        prod_lo_reg, prod_lo_next;
    logic signed [63:0]        prod_b_reg, prod_b_next;
    logic signed [50:0]        low_reg, low_next;
    logic signed [64:0]        hi_reg, hi_next;
    logic                      out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]        out_result_reg, out_result_next;
    logic [ROW_W-1:0]          out_row_reg, out_row_next;
    logic                      out_sat_reg, out_sat_next;

    logic signed [VALUE_W-1:0] sum_hi;
    logic signed [16:0]        sum_lo;
    logic signed [65:0]        scaled_res;
    logic signed [65:0]        plain_res;
    logic signed [65:0]        res_sel;
    logic                      out_free;

    always_comb
    begin
        sum_hi     = $signed(sum_reg[ACC_W-1:16]);
        sum_lo     = $signed({1'b0, sum_reg[15:0]});
        scaled_res = hi_reg + (low_reg >>> 16);
        plain_res  = sum_reg;
        res_sel    = scaled_mode ? scaled_res : plain_res;
        out_free   = !out_valid_reg || out_ready;

        state_next      = state_reg;
        sum_next        = sum_reg;
        old_next        = old_reg;
        clip_next       = clip_reg;
        row_next        = row_reg;
        prod_hi_next    = prod_hi_reg;
        prod_lo_next    = prod_lo_reg;
        prod_b_next     = prod_b_reg;
        low_next        = low_reg;
        hi_next         = hi_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_result_next = out_result_reg;
        out_row_next    = out_row_reg;
        out_sat_next    = out_sat_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (fin.valid)
                begin
                    sum_next   = fin.sum;
                    old_next   = fin.old;
                    clip_next  = fin.clip;
                    row_next   = fin.row;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // alpha*sum split as alpha*floor(sum/2^16) and alpha*(sum mod 2^16)
                prod_hi_next = alpha_gain * sum_hi;
                prod_lo_next = alpha_gain * sum_lo;
                prod_b_next  = beta_gain * old_reg;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                low_next   = prod_lo_reg + $signed({1'b0, prod_b_reg[15:0]}) + 51'sd32768;
                hi_next    = prod_hi_reg + (prod_b_reg >>> 16);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = row_reg;
                    if (res_sel > RES_MAX)
                    begin
                        out_result_next = RES_MAX[VALUE_W-1:0];
                        out_sat_next    = 1'b1;
                    end
                    else if (res_sel < RES_MIN)
                    begin
                        out_result_next = RES_MIN[VALUE_W-1:0];
                        out_sat_next    = 1'b1;
                    end
                    else
                    begin
                        out_result_next = res_sel[VALUE_W-1:0];
                        out_sat_next    = clip_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sum_reg        <= '0;
            old_reg        <= '0;
            clip_reg       <= 1'b0;
            row_reg        <= '0;
            prod_hi_reg    <= '0;
            prod_lo_reg    <= '0;
            prod_b_reg     <= '0;
            low_reg        <= '0;
            hi_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_result_reg <= '0;
            out_row_reg    <= '0;
            out_sat_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sum_reg        <= sum_next;
            old_reg        <= old_next;
            clip_reg       <= clip_next;
            row_reg        <= row_next;
            prod_hi_reg    <= prod_hi_next;
            prod_lo_reg    <= prod_lo_next;
            prod_b_reg     <= prod_b_next;
            low_reg        <= low_next;
            hi_reg         <= hi_next;
            out_valid_reg  <= out_valid_next;
            out_result_reg <= out_result_next;
            out_row_reg    <= out_row_next;
            out_sat_reg    <= out_sat_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign out_row    = out_row_reg;
    assign out_sat    = out_sat_reg;
    assign idle       = (state_reg == ST_IDLE);

endmodule

FILE: rtl/pattern_spmv_accumulate.sv
// Pattern-only CSR sparse matrix times dense vector, Q16.16, one row result per row.
// Loads and non-final entries: one transfer per cycle when s_tready is high, store read
// in the cycle after. Row-closing transfer: its scaled result goes out on m_tvalid;
// s_tready is low from hand-off through multiply, sum and clip (longer if output held).
// Reset (rst_n, async, low) clears the row sum, row count and pipeline; the vector
// store is not cleared and holds whatever was loaded.
module pattern_spmv_accumulate
    import psa_pkg::*;
#(
    parameter int VECTOR_DEPTH = 4096,
    parameter int MAX_ROWS     = 65536
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // index[11:0], value[43:12], zero pad[47:44]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    input  logic        s_tlast,   // row_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // row_result[31:0], row_number[47:32]
    output logic        m_tuser,   // saturated[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(VECTOR_DEPTH);

    logic                      scaled_mode_reg;
    logic signed [VALUE_W-1:0] alpha_gain_reg;
    logic signed [VALUE_W-1:0] beta_gain_reg;

    logic [INDEX_W-1:0]        in_index;
    logic signed [VALUE_W-1:0] in_value;
    logic                      take;
    logic                      idx_ok;
    logic [AW+INDEX_W-1:0]     addr_wide;
    logic [AW-1:0]             addr;
    logic [VALUE_W-1:0]        rd_data;
    fin_t                      fin;
    logic                      pend;
    logic                      scale_idle;
    logic [VALUE_W-1:0]        res_data;
    logic [ROW_W-1:0]          res_row;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scaled_mode_reg <= 1'b0;
            alpha_gain_reg  <= 32'sd65536;
            beta_gain_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SCALED_MODE: scaled_mode_reg <= cfg_data[0];
                CFG_ALPHA_GAIN:  alpha_gain_reg  <= $signed(cfg_data);
                CFG_BETA_GAIN:   beta_gain_reg   <= $signed(cfg_data);
                default:         ;
            endcase
        end
    end

    assign in_index  = s_tdata[INDEX_W-1:0];
    assign in_value  = $signed(s_tdata[INDEX_W+VALUE_W-1:INDEX_W]);
    assign take      = s_tvalid && s_tready;
    assign idx_ok    = ({20'd0, in_index} < 32'(VECTOR_DEPTH));
    assign addr_wide = {{AW{1'b0}}, in_index};
    assign addr      = addr_wide[AW-1:0];

    // hold off input while a closed row is on its way into the scaler or the scaler is busy
    assign s_tready = scale_idle && !pend;

    psa_vec_mem #(
        .DEPTH(VECTOR_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (take && (s_tuser == MODE_LOAD) && idx_ok),
        .wr_addr (addr),
        .wr_data (s_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
        .rd_en   (take && (s_tuser == MODE_ENTRY)),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    psa_accum #(
        .MAX_ROWS(MAX_ROWS)
    ) u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .mode    (s_tuser),
        .idx_ok  (idx_ok),
        .last    (s_tlast),
        .old     (in_value),
        .rd_data (rd_data),
        .fin     (fin),
        .pend    (pend)
    );

    psa_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .scaled_mode (scaled_mode_reg),
        .alpha_gain  (alpha_gain_reg),
        .beta_gain   (beta_gain_reg),
        .fin         (fin),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_result  (res_data),
        .out_row     (res_row),
        .out_sat     (m_tuser),
        .idle        (scale_idle)
    );

    assign m_tdata = {res_row, res_data};

    // a closed row is only handed over when the scaler can take it
    assert property (@(posedge clk) disable iff (!rst_n) fin.valid |-> scale_idle)
        else $error("row handed to busy scaler");

    // no transfer right after a row closes, while the scaler starts work
    assert property (@(posedge clk) disable iff (!rst_n) fin.valid |=> !s_tready)
        else $error("input accepted during row hand-off");

    // a new result only appears after the scaler has been busy
    assert property (@(posedge clk) disable iff (!rst_n) $rose(m_tvalid) |-> $past(!scale_idle))
        else $error("result without a computed row");

endmodule
